### rtl/core/marker_record_field_parser_top_macros.svh
// Assertion macros shared by the marker record field parser RTL.
// Each macro expects clk_i and an active-low rst_ni in the including module.
`ifndef MARKER_RECORD_FIELD_PARSER_TOP_MACROS_SVH
`define MARKER_RECORD_FIELD_PARSER_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define MRFP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MRFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mrfp_pkg.sv
// Package of the marker record field parser: widths, character codes,
// field kinds and the request types passed between front, queue and back.
`timescale 1ns / 1ps

package mrfp_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned LongValW = 14;
  localparam int unsigned ShortValW = 7;
  localparam int unsigned CntW     = 4;
  localparam int unsigned BudgetW  = 3;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CharW-1:0] CharStar = 8'h2A;
  localparam logic [CharW-1:0] CharM    = 8'h4D;
  localparam logic [CharW-1:0] CharT    = 8'h54;
  localparam logic [CharW-1:0] Char0    = 8'h30;
  localparam logic [CharW-1:0] Char9    = 8'h39;

  localparam logic [BudgetW-1:0] LongBudget  = 3'd4;
  localparam logic [BudgetW-1:0] ShortBudget = 3'd2;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_CHANGE = 3'd1,
    KIND_NOW    = 3'd2,
    KIND_MODE   = 3'd3,
    KIND_TIME   = 3'd4
  } field_kind_e;

  // One parsed record as it leaves the parser.
  typedef struct packed {
    logic [IdxW-1:0]      index;
    logic [LongValW-1:0]  change;
    logic [LongValW-1:0]  now;
    logic [ShortValW-1:0] mode;
    logic [ShortValW-1:0] tim;
  } record_t;

  // Request queued between front and back: a record, a summary or both.
  typedef struct packed {
    logic            has_rec;
    logic            has_sum;
    record_t         rec;
    logic [CntW-1:0] count;
    logic            ovf;
  } work_t;

endpackage

### rtl/core/mrfp_front.sv
// Front part: accepts characters, runs the field parser and classifies the
// step into a record request, a summary request or both. Uses mrfp_pkg.
`timescale 1ns / 1ps

module mrfp_front import mrfp_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] char_i,
  input  logic             last_i,
  input  logic             full_i,
  output logic             push_o,
  output work_t            push_data_o
);

  typedef struct packed {
    logic                 sp;
    field_kind_e          kind;
    logic [BudgetW-1:0]   dl;
    logic [LongValW-1:0]  acc;
    logic [LongValW-1:0]  chg;
    logic [LongValW-1:0]  now;
    logic [ShortValW-1:0] mode;
    logic [ShortValW-1:0] tim;
    logic [CntW-1:0]      cnt;
    logic                 ovf;
  } parse_state_t;

  typedef struct packed {
    parse_state_t st;
    logic         emit_ok;
    record_t      rec;
  } close_res_t;

  parse_state_t state_q, state_d, nxt;
  close_res_t   cl;
  record_t      rec;
  logic         emit, star_now, done, digit, in_fire;

  function automatic logic is_open(field_kind_e k);
    return (k == KIND_CHANGE) || (k == KIND_NOW) || (k == KIND_MODE) || (k == KIND_TIME);
  endfunction

  // Close the open field; closing the time field completes the record.
  function automatic close_res_t close_field(parse_state_t s);
    close_res_t r;
    r         = '0;
    r.st      = s;
    r.st.kind = KIND_NONE;
    r.st.dl   = '0;
    r.st.acc  = '0;
    case (s.kind)
      KIND_CHANGE: r.st.chg  = s.acc;
      KIND_NOW:    r.st.now  = s.acc;
      KIND_MODE:   r.st.mode = s.acc[ShortValW-1:0];
      KIND_TIME: begin
        r.rec = '{index: s.cnt, change: s.chg, now: s.now, mode: s.mode,
                  tim: s.acc[ShortValW-1:0]};
        if (s.cnt < CntW'(MAX_RECORDS)) begin
          r.emit_ok = 1'b1;
          r.st.cnt  = s.cnt + CntW'(1);
        end else begin
          r.st.ovf = 1'b1;
        end
        r.st.chg  = '0;
        r.st.now  = '0;
        r.st.mode = '0;
        r.st.tim  = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign in_ready_o = !full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign digit      = (char_i >= Char0) && (char_i <= Char9);

  always_comb begin
    nxt      = state_q;
    cl       = '0;
    rec      = '0;
    emit     = 1'b0;
    star_now = 1'b0;
    done     = 1'b0;

    // A pending star becomes either a now field or a change field.
    if (nxt.sp) begin
      nxt.sp  = 1'b0;
      nxt.dl  = LongBudget;
      nxt.acc = '0;
      if (char_i == CharStar) begin
        nxt.kind = KIND_NOW;
        star_now = 1'b1;
      end else begin
        nxt.kind = KIND_CHANGE;
      end
    end

    if (!star_now) begin
      if (is_open(nxt.kind)) begin
        if (digit && (nxt.dl != '0)) begin
          nxt.acc = LongValW'((nxt.acc << 3) + (nxt.acc << 1) + LongValW'(char_i[3:0]));
          nxt.dl  = nxt.dl - BudgetW'(1);
          if (nxt.dl == '0) begin
            cl  = close_field(nxt);
            nxt = cl.st;
            if (cl.emit_ok) begin
              emit = 1'b1;
              rec  = cl.rec;
            end
          end
          done = 1'b1;
        end else begin
          cl  = close_field(nxt);
          nxt = cl.st;
          if (cl.emit_ok) begin
            emit = 1'b1;
            rec  = cl.rec;
          end
        end
      end else begin
        nxt.kind = KIND_NONE;
      end

      // Open a new field on a marker; stray digits and others are dropped.
      if (!done && !digit) begin
        if (char_i == CharStar) begin
          nxt.sp = 1'b1;
        end else if (char_i == CharM) begin
          nxt.kind = KIND_MODE;
          nxt.dl   = ShortBudget;
          nxt.acc  = '0;
        end else if (char_i == CharT) begin
          nxt.kind = KIND_TIME;
          nxt.dl   = ShortBudget;
          nxt.acc  = '0;
        end
      end
    end

    push_data_o         = '0;
    push_data_o.has_rec = 1'b0;

    // Message end: close whatever is open, then summarise and restart.
    if (last_i) begin
      if (nxt.sp) begin
        nxt.sp   = 1'b0;
        nxt.kind = KIND_CHANGE;
        nxt.dl   = LongBudget;
        nxt.acc  = '0;
      end
      if (is_open(nxt.kind)) begin
        cl  = close_field(nxt);
        nxt = cl.st;
        if (cl.emit_ok && !emit) begin
          emit = 1'b1;
          rec  = cl.rec;
        end
      end
      push_data_o.count = nxt.cnt;
      push_data_o.ovf   = nxt.ovf;
      nxt = '0;
    end

    push_data_o.has_rec = emit;
    push_data_o.has_sum = last_i;
    push_data_o.rec     = rec;
    push_o              = in_fire && (emit || last_i);
    state_d             = in_fire ? nxt : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

`include "marker_record_field_parser_top_macros.svh"

  `MRFP_ASSERT_NEXT(a_front_restart, in_fire && last_i, state_q == '0, "parser not restarted after message end")

endmodule

### rtl/core/mrfp_queue.sv
// Short request queue between the parser front and the output back part.
// Uses mrfp_pkg for the request type and depth.
`timescale 1ns / 1ps

module mrfp_queue import mrfp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output work_t pop_data_o,
  output logic  not_empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  work_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;

  assign full_o      = (fill_q == FillW'(QueueDepth));
  assign not_empty_o = (fill_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + FillW'(1);
      2'b01:   fill_d = fill_q - FillW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`include "marker_record_field_parser_top_macros.svh"

  `MRFP_ASSERT_IMP(a_queue_no_overrun, push_i, !full_o, "request pushed into full queue")
  `MRFP_ASSERT_IMP(a_queue_no_underrun, pop_i, not_empty_o, "request popped from empty queue")

endmodule

### rtl/core/mrfp_back.sv
// Back part: takes requests from the queue and presents each record and
// summary in the output register, one result per cycle while the receiver is ready. Uses mrfp_pkg.
`timescale 1ns / 1ps

module mrfp_back import mrfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  work_t               q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_sum_o,
  output logic [OutDataW-1:0] out_data_o
);

  logic                out_valid_q, out_valid_d;
  logic                out_sum_q, out_sum_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                pend_q, pend_d;
  logic [CntW-1:0]     pend_cnt_q, pend_cnt_d;
  logic                pend_ovf_q, pend_ovf_d;
  logic                load;

  function automatic logic [OutDataW-1:0] pack_record(record_t r);
    return OutDataW'({1'b0, {CntW{1'b0}}, r.tim, r.mode, r.now, r.change, r.index});
  endfunction

  function automatic logic [OutDataW-1:0] pack_summary(logic [CntW-1:0] cnt, logic ovf);
    return OutDataW'({ovf, cnt, {(2 * ShortValW + 2 * LongValW + IdxW){1'b0}}});
  endfunction

  assign load = !out_valid_q || out_ready_i;
  assign pop_o = load && !pend_q && q_valid_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    out_data_d  = out_data_q;
    pend_d      = pend_q;
    pend_cnt_d  = pend_cnt_q;
    pend_ovf_d  = pend_ovf_q;
    if (load) begin
      if (pend_q) begin
        // Summary held back behind its record.
        out_valid_d = 1'b1;
        out_sum_d   = 1'b1;
        out_data_d  = pack_summary(pend_cnt_q, pend_ovf_q);
        pend_d      = 1'b0;
      end else if (q_valid_i) begin
        out_valid_d = 1'b1;
        if (q_data_i.has_rec) begin
          out_sum_d  = 1'b0;
          out_data_d = pack_record(q_data_i.rec);
          pend_d     = q_data_i.has_sum;
          pend_cnt_d = q_data_i.count;
          pend_ovf_d = q_data_i.ovf;
        end else begin
          out_sum_d  = 1'b1;
          out_data_d = pack_summary(q_data_i.count, q_data_i.ovf);
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sum_q  <= out_sum_d;
    out_data_q <= out_data_d;
    pend_cnt_q <= pend_cnt_d;
    pend_ovf_q <= pend_ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;
  assign out_data_o  = out_data_q;

`include "marker_record_field_parser_top_macros.svh"

  `MRFP_ASSERT_ALWAYS(a_back_pend_behind_rec, !pend_q || (out_valid_q && !out_sum_q), "pending summary without a record shown")
  `MRFP_ASSERT_IMP(a_back_no_pop_pending, pop_o, !pend_q, "request popped while summary pending")

endmodule

### rtl/core/marker_record_field_parser_top.sv
// Marker record field parser, top level. Results pass to the master side through
// the queue, written at the accepting edge, and then the output register.
// One character per cycle while the queue has room; a character ending both a record
// and the message gives two results, so a run of those holds input back once the
// four-entry queue fills.
// Reset (rst_ni low, asynchronous): parser state, queue and output valid clear.
`timescale 1ns / 1ps

module marker_record_field_parser_top import mrfp_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Slave side: one message character per request.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [CharW-1:0]    s_axis_tdata_i,   // [7:0] char_code
  input  logic                s_axis_tlast_i,   // message_end
  // Master side: records, then the message summary.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [3:0] record_index, [17:4] change_value, [31:18] now_value,
  // [38:32] mode_value, [45:39] time_value, [49:46] record_count,
  // [50] overflowed, [55:51] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tuser_o    // is_summary
);

  logic  push, full, pop, not_empty;
  work_t push_data, pop_data;

  // Front: parse each character and classify the step.
  mrfp_front #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .char_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue: decouple parsing from output back-pressure.
  mrfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .not_empty_o (not_empty)
  );

  // Back: expand each request into its record and summary results.
  mrfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (not_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_sum_o   (m_axis_tuser_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

### tb/tb.sv
// Self-checking testbench of marker_record_field_parser_top: feeds character messages on the
// slave stream and checks every record and summary on the master stream against a predictor.
// Depends on mrfp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb;
  import mrfp_pkg::*;

  localparam int unsigned Capacity    = 15;
  localparam int unsigned PhaseItems  = 460;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned MaxReported = 10;

  localparam logic [CharW-1:0] CharBlank = 8'h20;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharComma = 8'h2C;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;

  typedef struct packed {
    logic                 summary;
    logic [IdxW-1:0]      idx;
    logic [LongValW-1:0]  change;
    logic [LongValW-1:0]  now;
    logic [ShortValW-1:0] mode;
    logic [ShortValW-1:0] tim;
    logic [CntW-1:0]      count;
    logic                 ovf;
  } parse_result_t;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [CharW-1:0]    s_axis_tdata   = '0;
  logic                s_axis_tlast   = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned chars_accepted    = 0;
  int unsigned results_checked   = 0;
  int unsigned mismatch_count    = 0;

  parse_result_t    awaited_results[$];
  logic [CharW-1:0] message_chars[$];

  // Parser state as the predictor sees it.
  logic                 star_seen;
  field_kind_e          open_kind;
  logic [BudgetW-1:0]   digits_budget;
  logic [LongValW-1:0]  digit_acc;
  logic [LongValW-1:0]  rec_change;
  logic [LongValW-1:0]  rec_now;
  logic [ShortValW-1:0] rec_mode;
  logic [ShortValW-1:0] rec_time;
  logic [CntW-1:0]      records_done;
  logic                 records_dropped;
  logic                 record_sent;

  marker_record_field_parser_top #(
    .MAX_RECORDS(Capacity)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_parser_state();
    star_seen       = 1'b0;
    open_kind       = KIND_NONE;
    digits_budget   = '0;
    digit_acc       = '0;
    rec_change      = '0;
    rec_now         = '0;
    rec_mode        = '0;
    rec_time        = '0;
    records_done    = '0;
    records_dropped = 1'b0;
  endfunction

  function automatic void start_field(field_kind_e kind, logic [BudgetW-1:0] budget);
    open_kind     = kind;
    digits_budget = budget;
    digit_acc     = '0;
  endfunction

  // Only the first record completed by one character leaves the block; a second is counted.
  function automatic void complete_record();
    parse_result_t rec;
    if (records_done < Capacity) begin
      if (!record_sent) begin
        rec        = '0;
        rec.idx    = records_done;
        rec.change = rec_change;
        rec.now    = rec_now;
        rec.mode   = rec_mode;
        rec.tim    = rec_time;
        awaited_results.push_back(rec);
        record_sent = 1'b1;
      end
      records_done = records_done + 1'b1;
    end else begin
      records_dropped = 1'b1;
    end
    rec_change = '0;
    rec_now    = '0;
    rec_mode   = '0;
    rec_time   = '0;
  endfunction

  function automatic void close_field();
    field_kind_e         kind;
    logic [LongValW-1:0] value;
    kind          = open_kind;
    value         = digit_acc;
    open_kind     = KIND_NONE;
    digits_budget = '0;
    digit_acc     = '0;
    case (kind)
      KIND_CHANGE: rec_change = value;
      KIND_NOW:    rec_now = value;
      KIND_MODE:   rec_mode = value[ShortValW-1:0];
      KIND_TIME: begin
        rec_time = value[ShortValW-1:0];
        complete_record();
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_char(logic [CharW-1:0] c, logic is_last);
    logic          is_digit;
    logic          consumed;
    parse_result_t summary;
    is_digit    = (c >= Char0) && (c <= Char9);
    consumed    = 1'b0;
    record_sent = 1'b0;
    // A pending star becomes a now field on a second star, otherwise a change field.
    if (star_seen) begin
      star_seen = 1'b0;
      if (c == CharStar) begin
        start_field(KIND_NOW, LongBudget);
        consumed = 1'b1;
      end else begin
        start_field(KIND_CHANGE, LongBudget);
      end
    end
    if (!consumed && open_kind != KIND_NONE) begin
      if (is_digit && digits_budget != 0) begin
        digit_acc     = digit_acc * 4'd10 + (c - Char0);
        digits_budget = digits_budget - 1'b1;
        if (digits_budget == 0) close_field();
        consumed = 1'b1;
      end else begin
        close_field();
      end
    end
    if (!consumed && !is_digit) begin
      if (c == CharStar) star_seen = 1'b1;
      else if (c == CharM) start_field(KIND_MODE, ShortBudget);
      else if (c == CharT) start_field(KIND_TIME, ShortBudget);
    end
    if (is_last) begin
      if (star_seen) begin
        star_seen = 1'b0;
        start_field(KIND_CHANGE, LongBudget);
      end
      if (open_kind != KIND_NONE) close_field();
      summary         = '0;
      summary.summary = 1'b1;
      summary.count   = records_done;
      summary.ovf     = records_dropped;
      awaited_results.push_back(summary);
      clear_parser_state();
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void report_mismatch(string msg);
    if (mismatch_count < MaxReported) $display("mismatch at result %0d: %s", results_checked, msg);
    mismatch_count++;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
  endfunction

  always @(posedge clk_i) begin : result_check
    parse_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, tdata %h tuser %b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = awaited_results.pop_front();
        compare_field("is_summary", want.summary, m_axis_tuser);
        compare_field("record_index", want.idx, m_axis_tdata[3:0]);
        compare_field("change_value", want.change, m_axis_tdata[17:4]);
        compare_field("now_value", want.now, m_axis_tdata[31:18]);
        compare_field("mode_value", want.mode, m_axis_tdata[38:32]);
        compare_field("time_value", want.tim, m_axis_tdata[45:39]);
        compare_field("record_count", want.count, m_axis_tdata[49:46]);
        compare_field("overflowed", want.ovf, m_axis_tdata[50]);
        compare_field("padding", 0, m_axis_tdata[55:51]);
      end
      results_checked++;
    end
  end

  // Hold the receiver back at random, as the current phase asks.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no request moved for %0d cycles", StallLimit);
    $display("** marker_record_field_parser_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  // Called at a rising edge; returns at the edge where the character is taken.
  task automatic send_char(logic [CharW-1:0] c, logic is_last);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= CharW'($urandom);
      s_axis_tlast  <= 1'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_char(c, is_last);
    chars_accepted++;
  endtask

  task automatic send_message();
    int unsigned len;
    len = message_chars.size();
    for (int unsigned i = 0; i < len; i++) send_char(message_chars[i], i == len - 1);
    message_chars.delete();
  endtask

  function automatic void push_text(string s);
    foreach (s[i]) message_chars.push_back(s[i]);
  endfunction

  function automatic logic [CharW-1:0] random_digit();
    case ($urandom_range(0, 9))
      0: return Char9;
      1: return Char0;
      default: return CharW'(Char0 + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [CharW-1:0] noise_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return CharStar;
    if (pick < 17) return CharM;
    if (pick < 25) return CharT;
    if (pick < 60) return random_digit();
    return CharW'($urandom_range(0, 255));
  endfunction

  // Mostly within budget; now and then one digit too many, which falls out as a stray.
  function automatic void push_number(int unsigned budget);
    int unsigned digits;
    digits = ($urandom_range(0, 9) == 0) ? budget + 1 : $urandom_range(0, budget);
    repeat (digits) message_chars.push_back(random_digit());
  endfunction

  function automatic void push_separator();
    case ($urandom_range(0, 11))
      0: message_chars.push_back(CharBlank);
      1: message_chars.push_back(CharComma);
      2: message_chars.push_back(CharPlus);
      3: message_chars.push_back(CharMinus);
      4: message_chars.push_back(CharW'($urandom_range(0, 255)));
      default: ;
    endcase
  endfunction

  function automatic void push_record(logic compact);
    if (!compact) begin
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 2))
          0: message_chars.push_back(CharStar);
          1: begin
            message_chars.push_back(CharStar);
            message_chars.push_back(CharStar);
          end
          default: message_chars.push_back(CharM);
        endcase
        push_number(message_chars[$] == CharM ? ShortBudget : LongBudget);
        push_separator();
      end
    end
    message_chars.push_back(CharT);
    push_number(ShortBudget);
    push_separator();
  endfunction

  // Well-formed records with random content, some long enough to overrun capacity,
  // plus pure noise and messages cut off in the middle of a record.
  function automatic void build_random_message();
    int unsigned records;
    if ($urandom_range(0, 99) < 25) begin
      repeat ($urandom_range(1, 12)) message_chars.push_back(noise_char());
    end else begin
      records = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 4);
      repeat (records) push_record(records > 12);
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) message_chars.push_back(noise_char());
      end
      if (message_chars.size() == 0) message_chars.push_back(noise_char());
    end
  endfunction

  task automatic run_random_messages(int unsigned items);
    int unsigned goal;
    goal = chars_accepted + items;
    while (chars_accepted < goal) begin
      build_random_message();
      send_message();
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_field_extremes();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    push_text("*9999**9999T99");
    send_message();
  endtask

  // Stray digit, star before another marker, record closed by the last character,
  // two records ending together, blank ending a field, lone star at the end.
  task automatic test_special_cases();
    push_text("5*M1T");
    send_message();
    push_text("T1T");
    send_message();
    message_chars.push_back(8'h00);
    message_chars.push_back(CharM);
    message_chars.push_back(CharBlank);
    message_chars.push_back(CharW'(Char0 + 4));
    message_chars.push_back(8'hFF);
    message_chars.push_back(CharStar);
    send_message();
  endtask

  task automatic test_random_no_idling();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random_messages(PhaseItems);
  endtask

  task automatic test_random_sender_idle();
    sender_idle_pct    = 76;
    receiver_stall_pct = 0;
    run_random_messages(PhaseItems);
  endtask

  task automatic test_random_receiver_stall();
    sender_idle_pct    = 0;
    receiver_stall_pct = 76;
    run_random_messages(PhaseItems);
  endtask

  task automatic test_random_both_idle();
    sender_idle_pct    = 24;
    receiver_stall_pct = 24;
    run_random_messages(PhaseItems);
  endtask

  initial begin
    clear_parser_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_special_cases();
    test_random_no_idling();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("** marker_record_field_parser_top: PASSED **");
    end else begin
      $display("** marker_record_field_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
